// ===== hdl/lbac_pkg.sv =====
// shared types, codes and constants for the layer blitter
package lbac_pkg;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int QUEUE_DEPTH    = 4;

	localparam int CH_W   = 8;
	localparam int SURF_W = 10;
	localparam int PIX_W  = 4 * CH_W;

	localparam logic [SURF_W-1:0] SURF_RESET   = 10'd512;
	localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'd255;
	localparam logic [CH_W-1:0]   ALPHA_CLEAR  = 8'd0;
	localparam logic [15:0]       BLEND_ROUND  = 16'd127;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_PIXEL = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic {
		CFG_SURF_W = 1'b0,
		CFG_SURF_H = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_DRAW     = 2'd0,
		CMD_CLEAR    = 2'd1,
		CMD_READ     = 2'd2,
		CMD_READ_OOR = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] a;
	} cmd_t;

endpackage

// ===== hdl/lbac_ram.sv =====
// generic simple dual-port ram with registered read
module lbac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== hdl/lbac_fifo.sv =====
// short command queue between front and back
module lbac_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign dout  = entry_q[rd_ptr_q];
	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== hdl/lbac_front.sv =====
// front: layer state, raster counters, clipping and command classification
module lbac_front import lbac_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [SURF_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic signed [15:0]  pos_x,
	input  logic signed [15:0]  pos_y,
	input  logic signed [15:0]  off_x,
	input  logic signed [15:0]  off_y,
	input  logic [11:0]         layer_w,
	input  logic [11:0]         layer_h,
	input  logic                visible,
	input  logic [CH_W-1:0]     src_r,
	input  logic [CH_W-1:0]     src_g,
	input  logic [CH_W-1:0]     src_b,
	input  logic [CH_W-1:0]     src_a,
	input  logic                q_full,
	output logic                push,
	output cmd_t                push_cmd,
	output logic [XW-1:0]       push_x,
	output logic [YW-1:0]       push_y
);

	logic [SURF_W-1:0]   surf_w_q;
	logic [SURF_W-1:0]   surf_h_q;
	logic signed [17:0]  org_x_q;
	logic signed [17:0]  org_y_q;
	logic [11:0]         lay_w_q;
	logic [11:0]         lay_h_q;
	logic                shown_q;
	logic [11:0]         col_q;
	logic [12:0]         row_q;

	logic                accept;
	logic signed [18:0]  eff_w;
	logic signed [18:0]  eff_h;
	logic signed [18:0]  sel_x;
	logic signed [18:0]  sel_y;
	logic                on_surf;
	logic                in_layer;
	logic [11:0]         col_inc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		eff_w = ({9'b0, surf_w_q} < 19'(MAX_WIDTH)) ? {9'b0, surf_w_q} : 19'(MAX_WIDTH);
		eff_h = ({9'b0, surf_h_q} < 19'(MAX_HEIGHT)) ? {9'b0, surf_h_q} : 19'(MAX_HEIGHT);

		// pixels land at origin plus raster position, other ops use pos directly
		if (op_t'(op) == OP_PIXEL) begin
			sel_x = 19'(org_x_q) + $signed({7'b0, col_q});
			sel_y = 19'(org_y_q) + $signed({6'b0, row_q});
		end else begin
			sel_x = 19'(pos_x);
			sel_y = 19'(pos_y);
		end

		on_surf  = !sel_x[18] && (sel_x < eff_w) && !sel_y[18] && (sel_y < eff_h);
		in_layer = (lay_w_q != '0) && ({1'b0, lay_h_q} > row_q);
		col_inc  = col_q + 12'd1;

		push_x = sel_x[XW-1:0];
		push_y = sel_y[YW-1:0];
		push_cmd.r = src_r;
		push_cmd.g = src_g;
		push_cmd.b = src_b;
		push_cmd.a = src_a;
		push_cmd.kind = CMD_DRAW;
		push = 1'b0;

		case (op_t'(op))
			OP_PIXEL: begin
				push_cmd.kind = CMD_DRAW;
				push = accept && in_layer && shown_q && on_surf && (src_a != ALPHA_CLEAR);
			end
			OP_READ: begin
				push_cmd.kind = on_surf ? CMD_READ : CMD_READ_OOR;
				push = accept;
			end
			OP_CLEAR: begin
				push_cmd.kind = CMD_CLEAR;
				push = accept && on_surf;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_w_q <= SURF_RESET;
			surf_h_q <= SURF_RESET;
			org_x_q  <= '0;
			org_y_q  <= '0;
			lay_w_q  <= '0;
			lay_h_q  <= '0;
			shown_q  <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SURF_W: surf_w_q <= cfg_data;
					CFG_SURF_H: surf_h_q <= cfg_data;
					default: begin
						surf_w_q <= surf_w_q;
					end
				endcase
			end
			if (accept && op_t'(op) == OP_BEGIN) begin
				org_x_q <= 18'(pos_x) + 18'(off_x);
				org_y_q <= 18'(pos_y) + 18'(off_y);
				lay_w_q <= layer_w;
				lay_h_q <= layer_h;
				shown_q <= visible;
				col_q   <= '0;
				row_q   <= '0;
			end else if (accept && op_t'(op) == OP_PIXEL && in_layer) begin
				// counters advance even for hidden or clipped pixels
				if (col_inc >= lay_w_q) begin
					col_q <= '0;
					row_q <= row_q + 13'd1;
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

endmodule

// ===== hdl/lbac_back.sv =====
// back: frame store read-modify-write pipeline and result register
module lbac_back import lbac_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT),
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	output logic            pop,
	input  cmd_t            head_cmd,
	input  logic [XW-1:0]   head_x,
	input  logic [YW-1:0]   head_y,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CH_W-1:0] pix_r,
	output logic [CH_W-1:0] pix_g,
	output logic [CH_W-1:0] pix_b,
	output logic [CH_W-1:0] pix_a,
	output logic            out_of_range
);

	function automatic logic [CH_W-1:0] mix8(input logic [CH_W-1:0] s,
			input logic [CH_W-1:0] d, input logic [CH_W-1:0] a);
		logic [15:0] acc;
		acc = 16'({8'b0, s} * {8'b0, a}) + 16'({8'b0, d} * {8'b0, ALPHA_OPAQUE - a})
			+ BLEND_ROUND;
		return acc[15:8];
	endfunction

	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [AW-1:0]    addr_s1;
	logic             valid_s2;
	cmd_t             cmd_s2;
	logic [AW-1:0]    addr_s2;
	logic             fwd_s2;
	logic [PIX_W-1:0] fwd_data_s2;
	logic             out_valid_q;
	logic [CH_W-1:0]  pix_r_q;
	logic [CH_W-1:0]  pix_g_q;
	logic [CH_W-1:0]  pix_b_q;
	logic [CH_W-1:0]  pix_a_q;
	logic             oor_q;

	logic             advance;
	logic             s2_result;
	logic             s2_we;
	logic             ram_re;
	logic [AW-1:0]    head_addr;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] dst;
	logic [PIX_W-1:0] new_pix;
	logic [CH_W-1:0]  new_a;

	assign s2_result = valid_s2 && (cmd_s2.kind == CMD_READ || cmd_s2.kind == CMD_READ_OOR);
	// only a pending result can hold the pipeline
	assign advance   = !(s2_result && out_valid_q && !out_ready);
	assign pop       = advance && !q_empty;
	assign head_addr = AW'(head_y) * AW'(MAX_WIDTH) + AW'(head_x);
	assign ram_re    = advance && valid_s1
		&& (cmd_s1.kind == CMD_DRAW || cmd_s1.kind == CMD_READ);
	assign s2_we     = advance && valid_s2
		&& (cmd_s2.kind == CMD_DRAW || cmd_s2.kind == CMD_CLEAR);

	// write in flight at the same edge as the read is forwarded
	assign dst = fwd_s2 ? fwd_data_s2 : rd_data;

	always_comb begin
		new_a = ALPHA_OPAQUE;
		case (cmd_s2.kind)
			CMD_DRAW: begin
				if (cmd_s2.a == ALPHA_OPAQUE) begin
					new_pix = {ALPHA_OPAQUE, cmd_s2.b, cmd_s2.g, cmd_s2.r};
				end else begin
					new_a = cmd_s2.a + 8'(({8'b0, dst[31:24]} * {8'b0, ALPHA_OPAQUE - cmd_s2.a}
						+ BLEND_ROUND) >> 8);
					new_pix = {new_a, mix8(cmd_s2.b, dst[23:16], cmd_s2.a),
						mix8(cmd_s2.g, dst[15:8], cmd_s2.a), mix8(cmd_s2.r, dst[7:0], cmd_s2.a)};
				end
			end
			default: begin
				new_pix = '0;
			end
		endcase
	end

	lbac_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_frame (
		.clk     (clk),
		.we      (s2_we),
		.waddr   (addr_s2),
		.wdata   (new_pix),
		.re      (ram_re),
		.raddr   (addr_s1),
		.rdata_q (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= !q_empty;
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && s2_result) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1      <= head_cmd;
			addr_s1     <= head_addr;
			cmd_s2      <= cmd_s1;
			addr_s2     <= addr_s1;
			fwd_s2      <= s2_we && (addr_s2 == addr_s1);
			fwd_data_s2 <= new_pix;
		end
		if (advance && s2_result) begin
			if (cmd_s2.kind == CMD_READ) begin
				pix_r_q <= dst[7:0];
				pix_g_q <= dst[15:8];
				pix_b_q <= dst[23:16];
				pix_a_q <= dst[31:24];
				oor_q   <= 1'b0;
			end else begin
				pix_r_q <= '0;
				pix_g_q <= '0;
				pix_b_q <= '0;
				pix_a_q <= '0;
				oor_q   <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pix_r        = pix_r_q;
	assign pix_g        = pix_g_q;
	assign pix_b        = pix_b_q;
	assign pix_a        = pix_a_q;
	assign out_of_range = oor_q;

endmodule

// ===== hdl/layer_blit_alpha_composite.sv =====
// top level of the layer blitter with src-over compositing
//
// usage: write surface_width (index 0) and surface_height (index 1) on the
// cfg channel while idle; cfg_ready is always high. then send requests on
// the in channel: begin layer, one source pixel per request in raster order,
// read pixel, clear pixel. only a read returns a result on the out channel,
// carrying the stored rgba and out_of_range.
// throughput: one request per cycle while in_ready is high, set by the frame store with
// one write port and one read port doing a read-modify-write per pixel.
// a read result goes through the queue, stages s1 and s2 and the result register.
// a short queue sits between the classifying front and the store pipeline;
// when out_ready is low a pending read result holds the store pipeline, the
// queue fills and in_ready drops once it is full.
// reset clears layer state and counters and sets the surface size (512 x 512); the
// frame store is not cleared and holds nothing useful until written.
module layer_blit_alpha_composite import lbac_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [SURF_W-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic signed [15:0]  pos_x,
	input  logic signed [15:0]  pos_y,
	input  logic signed [15:0]  off_x,
	input  logic signed [15:0]  off_y,
	input  logic [11:0]         layer_w,
	input  logic [11:0]         layer_h,
	input  logic                visible,
	input  logic [CH_W-1:0]     src_r,
	input  logic [CH_W-1:0]     src_g,
	input  logic [CH_W-1:0]     src_b,
	input  logic [CH_W-1:0]     src_a,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CH_W-1:0]     pix_r,
	output logic [CH_W-1:0]     pix_g,
	output logic [CH_W-1:0]     pix_b,
	output logic [CH_W-1:0]     pix_a,
	output logic                out_of_range
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int QW = $bits(cmd_t) + XW + YW;

	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	cmd_t          push_cmd;
	logic [XW-1:0] push_x;
	logic [YW-1:0] push_y;
	cmd_t          head_cmd;
	logic [XW-1:0] head_x;
	logic [YW-1:0] head_y;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;

	assign cfg_ready = 1'b1;
	assign q_din     = {push_cmd, push_x, push_y};
	assign {head_cmd, head_x, head_y} = q_dout;

	lbac_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.off_x     (off_x),
		.off_y     (off_y),
		.layer_w   (layer_w),
		.layer_h   (layer_h),
		.visible   (visible),
		.src_r     (src_r),
		.src_g     (src_g),
		.src_b     (src_b),
		.src_a     (src_a),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_x    (push_x),
		.push_y    (push_y)
	);

	lbac_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.pop    (pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	lbac_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.pop          (pop),
		.head_cmd     (head_cmd),
		.head_x       (head_x),
		.head_y       (head_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pix_r        (pix_r),
		.pix_g        (pix_g),
		.pix_b        (pix_b),
		.pix_a        (pix_a),
		.out_of_range (out_of_range)
	);

endmodule
